@@ sv/ftpc_pkg.sv @@
package ftpc_pkg;

  localparam int TEMP_W = 9;
  localparam int RPM_W  = 21;

  localparam logic [RPM_W-1:0] RPM_MAX = {RPM_W{1'b1}};

  localparam logic signed [TEMP_W-1:0] MIN_TEMP_RST = 9'sd50;
  localparam logic signed [TEMP_W-1:0] MAX_TEMP_RST = 9'sd100;

  // hysteresis below min_temp while the fan is running
  localparam logic signed [TEMP_W:0] HYST_DEG = 10'sd2;

  typedef enum logic [1:0] {
    CMD_TEMP = 2'd0,
    CMD_TACH = 2'd1,
    CMD_TICK = 2'd2
  } cmd_t;

  typedef enum logic {
    REG_MIN_TEMP = 1'b0,
    REG_MAX_TEMP = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_POST
  } state_t;

endpackage

@@ sv/fan_temp_pwm_tach_controller_core.sv @@
// Fan controller: a temperature sample (in_tuser = 0) sets a new PWM duty on a linear
// curve from min_temp to max_temp with 2 degrees of hysteresis on the off point and a
// 15 % floor; a tach edge (1) counts a pulse; an interval tick (2) latches rpm as
// pulses * 30 and clears the counter. Every transaction returns one result with the
// current duty, speed and speed-valid flag. A sample on the curve goes through the
// restoring divider, which produces one quotient bit per cycle; every other
// transaction goes straight to the result stage. The input is not ready while
// a transaction is in progress or its result has not yet been moved to the output
// register. Configuration registers are written through cfg_we/cfg_addr/cfg_wdata.
module fan_temp_pwm_tach_controller_core #(
  parameter int DUTY_FRAC_BITS = 10,
  parameter int COUNT_BITS     = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic                                cfg_addr,
  input  logic [ftpc_pkg::TEMP_W-1:0]         cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [15:0]                         in_tdata,   // [8:0] temperature
  input  logic [1:0]                          in_tuser,   // [1:0] cmd
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // duty (DUTY_FRAC_BITS+1), speed_rpm (21), zero fill
  output logic [((DUTY_FRAC_BITS+1+ftpc_pkg::RPM_W+7)/8)*8-1:0] out_tdata,
  output logic                                out_tuser   // [0] speed_valid
);
  import ftpc_pkg::*;

  localparam int DW          = DUTY_FRAC_BITS + 1;
  localparam int OUT_W       = ((DW + RPM_W + 7) / 8) * 8;
  localparam int MIN_DUTY_I  = ((2 ** DUTY_FRAC_BITS) * 15 + 50) / 100;
  localparam int PROD_W      = (COUNT_BITS + 5 > RPM_W) ? COUNT_BITS + 5 : RPM_W;
  localparam logic [DW-1:0] FULL_DUTY = {1'b1, {DUTY_FRAC_BITS{1'b0}}};
  localparam logic [DW-1:0] MIN_DUTY  = DW'(MIN_DUTY_I);

  state_t                   state_r, state_nxt;
  logic [DW-1:0]            duty_r, duty_nxt;
  logic [COUNT_BITS-1:0]    pulse_r, pulse_nxt;
  logic [RPM_W-1:0]         rpm_r, rpm_nxt;
  logic                     rpm_vld_r, rpm_vld_nxt;
  logic signed [TEMP_W-1:0] min_r, max_r;
  logic                     out_valid_r, out_valid_nxt;
  logic [DW-1:0]            out_duty_r;
  logic [RPM_W-1:0]         out_rpm_r;
  logic                     out_vld_r;
  logic                     out_load;

  logic signed [TEMP_W:0]   temp_s, min_s, max_s, off_s, num_s, den_s;
  logic [TEMP_W-1:0]        div_num;
  logic [TEMP_W-1:0]        div_den;
  logic                     div_start;
  logic                     div_done;
  logic [DW-1:0]            div_quo;
  logic [PROD_W-1:0]        rpm_prod;
  cmd_t                     in_cmd;

  assign in_cmd  = cmd_t'(in_tuser);
  assign temp_s  = {in_tdata[TEMP_W-1], in_tdata[TEMP_W-1:0]};
  assign min_s   = {min_r[TEMP_W-1], min_r};
  assign max_s   = {max_r[TEMP_W-1], max_r};
  assign off_s   = (duty_r == '0) ? min_s : (min_s - HYST_DEG);
  assign num_s   = temp_s - min_s;
  assign den_s   = max_s - min_s;
  // inside the hysteresis band the curve term is zero
  assign div_num = num_s[TEMP_W] ? '0 : num_s[TEMP_W-1:0];
  assign div_den = den_s[TEMP_W-1:0];

  // pulses * 30 as (p << 5) - (p << 1)
  assign rpm_prod = (PROD_W'(pulse_r) << 5) - (PROD_W'(pulse_r) << 1);

  ftpc_div #(
    .DUTY_FRAC_BITS(DUTY_FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    duty_nxt      = duty_r;
    pulse_nxt     = pulse_r;
    rpm_nxt       = rpm_r;
    rpm_vld_nxt   = rpm_vld_r;
    out_valid_nxt = out_valid_r;
    out_load      = 1'b0;
    in_tready     = 1'b0;
    div_start     = 1'b0;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_POST;
          case (in_cmd)
            CMD_TEMP: begin
              if (temp_s < off_s) begin
                duty_nxt = '0;
              end else if ((temp_s > max_s) || (den_s <= 10'sd0)) begin
                duty_nxt = FULL_DUTY;
              end else begin
                div_start = 1'b1;
                state_nxt = ST_DIV;
              end
            end
            CMD_TACH: begin
              if (pulse_r != {COUNT_BITS{1'b1}}) begin
                pulse_nxt = pulse_r + COUNT_BITS'(1);
              end
            end
            CMD_TICK: begin
              rpm_nxt     = (rpm_prod > PROD_W'(RPM_MAX)) ? RPM_MAX : rpm_prod[RPM_W-1:0];
              rpm_vld_nxt = 1'b1;
              pulse_nxt   = '0;
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          duty_nxt  = (div_quo < MIN_DUTY) ? MIN_DUTY : div_quo;
          state_nxt = ST_POST;
        end
      end
      ST_POST: begin
        if (!out_valid_r || out_tready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      duty_r      <= '0;
      pulse_r     <= '0;
      rpm_r       <= '0;
      rpm_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      duty_r      <= duty_nxt;
      pulse_r     <= pulse_nxt;
      rpm_r       <= rpm_nxt;
      rpm_vld_r   <= rpm_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MIN_TEMP_RST;
      max_r <= MAX_TEMP_RST;
    end else if (cfg_we) begin
      if (cfg_addr == REG_MIN_TEMP) begin
        min_r <= cfg_wdata;
      end else begin
        max_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_duty_r <= duty_r;
      out_rpm_r  <= rpm_r;
      out_vld_r  <= rpm_vld_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_rpm_r, out_duty_r});
  assign out_tuser  = out_vld_r;

endmodule

@@ sv/ftpc_div.sv @@
module ftpc_div #(
  parameter int DUTY_FRAC_BITS = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ftpc_pkg::TEMP_W-1:0] num,
  input  logic [ftpc_pkg::TEMP_W-1:0] den,
  output logic                      done,
  output logic [DUTY_FRAC_BITS:0]   quo
);
  import ftpc_pkg::*;

  localparam int QW    = DUTY_FRAC_BITS + 1;
  localparam int CNT_W = $clog2(QW + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [TEMP_W:0]   rem_r;
  logic [TEMP_W:0]   den_r;
  logic [QW-1:0]     quo_r;
  logic              ge;
  logic [TEMP_W:0]   diff;
  logic [TEMP_W:0]   rem_nxt;

  // num <= den, so the first step yields the integer bit and the rest the fraction;
  // remainder stays below den, so the shift never overflows
  assign ge      = (rem_r >= den_r);
  assign diff    = ge ? (rem_r - den_r) : rem_r;
  assign rem_nxt = {diff[TEMP_W-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CNT_W'(1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= CNT_W'(QW);
      rem_r <= {1'b0, num};
      den_r <= {1'b0, den};
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      rem_r <= rem_nxt;
      quo_r <= {quo_r[QW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
